FILE: rtl/core/qlr_pkg.sv
// Package for the quantized linear requantization block.
// Holds sizes, register indexes, item kinds, payload structs and the state type.
`timescale 1ns / 1ps
package qlr_pkg;
	localparam int MAX_IN = 1024;
	localparam int MAX_OUT = 64;
	localparam int COL_W = $clog2(MAX_IN);
	localparam int ROW_W = $clog2(MAX_OUT);
	localparam int WADDR_W = COL_W + ROW_W;
	localparam int CNT_W = COL_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGNED_MODE = 3'd0,
		REG_INPUT_ZP = 3'd1,
		REG_WEIGHT_ZP = 3'd2,
		REG_SCALE_MULT = 3'd3,
		REG_SCALE_SHIFT = 3'd4,
		REG_OUTPUT_ZP = 3'd5,
		REG_ROW_LENGTH = 3'd6,
		REG_OUTPUT_COUNT = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_WEIGHT = 2'd0,
		KIND_BIAS = 2'd1,
		KIND_ACT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] out_row;
		logic [9:0] in_column;
		logic [7:0] data_byte;
		logic signed [31:0] bias_word;
		logic row_end;
	} item_t;

	typedef struct packed {
		logic [5:0] result_index;
		logic [7:0] result_byte;
		logic result_last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_REQ
	} state_t;
endpackage

FILE: rtl/core/quantized_linear_requant.sv
// Top level of the int8/uint8 fully connected layer with exact requantization.
// Depends on qlr_pkg, qlr_ram and qlr_requant.
`timescale 1ns / 1ps
// Loads and activations without row_end are taken whenever busy is low. An activation
// with row_end starts a sweep over the output rows. Let n be the smaller of row_length
// (capped at 1024) and the number of activations received in the row. Each output row
// reads its bias, multiply-accumulates over the first n columns (weight and activation
// memories have one read port each), drains the pipeline and passes through the
// requantizer. busy is high for the whole sweep; each result shows for one cycle with
// strobe high and cannot be held off.
module quantized_linear_requant import qlr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  strobe,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic smode_q;
	logic [8:0] izp_q, wzp_q, ozp_q;
	logic [30:0] mult_q;
	logic [5:0] shift_q;
	logic [10:0] rlen_q;
	logic [6:0] ocnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smode_q <= 1'b1;
			izp_q <= '0;
			wzp_q <= '0;
			mult_q <= 31'h40000000;
			shift_q <= '0;
			ozp_q <= '0;
			rlen_q <= 11'd1024;
			ocnt_q <= 7'd64;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SIGNED_MODE: smode_q <= cfg_data[0];
				REG_INPUT_ZP: izp_q <= cfg_data[8:0];
				REG_WEIGHT_ZP: wzp_q <= cfg_data[8:0];
				REG_SCALE_MULT: mult_q <= cfg_data;
				REG_SCALE_SHIFT: shift_q <= cfg_data[5:0];
				REG_OUTPUT_ZP: ozp_q <= cfg_data[8:0];
				REG_ROW_LENGTH: rlen_q <= cfg_data[10:0];
				REG_OUTPUT_COUNT: ocnt_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [CNT_W-1:0] act_cnt_q;
	logic [CNT_W-1:0] len_q;
	logic [ROW_W:0] nout_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic [1:0] sub_q;
	logic [31:0] acc_q;
	logic valid_s1, valid_s2;
	logic rq_go, rq_done;
	logic [7:0] rq_byte;
	logic accept;
	logic [CNT_W-1:0] len_d;
	logic [ROW_W:0] nout_d;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	logic w_we, b_we, a_we;
	logic [WADDR_W-1:0] w_raddr;
	logic [7:0] w_rdata, a_rdata;
	logic [31:0] b_rdata;

	assign w_we = accept && (kind_t'(item.kind) == KIND_WEIGHT);
	assign b_we = accept && (kind_t'(item.kind) == KIND_BIAS);
	assign a_we = accept && (kind_t'(item.kind) == KIND_ACT) && (act_cnt_q < CNT_W'(MAX_IN));
	assign w_raddr = {row_q, col_q[COL_W-1:0]};

	qlr_ram #(.WIDTH(8), .DEPTH(MAX_OUT * MAX_IN)) u_wmem (
		.clk(clk), .we(w_we), .waddr({item.out_row, item.in_column}),
		.wdata(item.data_byte), .raddr(w_raddr), .rdata(w_rdata));
	qlr_ram #(.WIDTH(32), .DEPTH(MAX_OUT)) u_bmem (
		.clk(clk), .we(b_we), .waddr(item.out_row),
		.wdata(item.bias_word), .raddr(row_q), .rdata(b_rdata));
	qlr_ram #(.WIDTH(8), .DEPTH(MAX_IN)) u_amem (
		.clk(clk), .we(a_we), .waddr(act_cnt_q[COL_W-1:0]),
		.wdata(item.data_byte), .raddr(col_q[COL_W-1:0]), .rdata(a_rdata));

	always_comb begin
		logic [CNT_W-1:0] cnt_n;
		cnt_n = (act_cnt_q < CNT_W'(MAX_IN)) ? act_cnt_q + 1'b1 : act_cnt_q;
		len_d = (rlen_q > 11'(MAX_IN)) ? CNT_W'(MAX_IN) : CNT_W'(rlen_q);
		if (len_d > cnt_n) begin
			len_d = cnt_n;
		end
		nout_d = (ocnt_q > 7'(MAX_OUT)) ? (ROW_W+1)'(MAX_OUT) : (ROW_W+1)'(ocnt_q);
		if (nout_d == '0) begin
			nout_d = (ROW_W+1)'(1);
		end
	end

	// Multiply stage: operands arrive in the cycle after the read addresses.
	logic signed [9:0] x_s, w_s;
	logic signed [19:0] prod_s2;
	assign x_s = $signed({smode_q & a_rdata[7], a_rdata}) - $signed({izp_q[8], izp_q});
	assign w_s = $signed({smode_q & w_rdata[7], w_rdata}) - $signed({wzp_q[8], wzp_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_MAC) && (col_q < len_q);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= x_s * w_s;
	end

	always_comb begin
		state_d = state_q;
		rq_go = 1'b0;
		case (state_q)
			ST_IDLE: if (accept && kind_t'(item.kind) == KIND_ACT && item.row_end) begin
				state_d = ST_BIAS;
			end
			ST_BIAS: if (sub_q == 2'd1) begin
				state_d = ST_MAC;
			end
			ST_MAC: if (col_q >= len_q) begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: if (sub_q == 2'd1) begin
				state_d = ST_REQ;
				rq_go = 1'b1;
			end
			ST_REQ: if (rq_done) begin
				state_d = (ROW_W+1)'(row_q) + 1'b1 == nout_q ? ST_IDLE : ST_BIAS;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			sub_q <= '0;
			len_q <= '0;
			nout_q <= '0;
			acc_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					sub_q <= '0;
					if (a_we) begin
						act_cnt_q <= act_cnt_q + 1'b1;
					end
					if (state_d == ST_BIAS) begin
						len_q <= len_d;
						nout_q <= nout_d;
						act_cnt_q <= '0;
					end
				end
				ST_BIAS: begin
					sub_q <= (sub_q == 2'd1) ? 2'd0 : sub_q + 2'd1;
					col_q <= '0;
					if (sub_q == 2'd1) begin
						acc_q <= b_rdata;
					end
				end
				ST_MAC: begin
					if (col_q < len_q) begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: sub_q <= (sub_q == 2'd1) ? 2'd0 : sub_q + 2'd1;
				ST_REQ: if (rq_done) begin
					row_q <= row_q + 1'b1;
				end
				default: ;
			endcase
			if (valid_s2) begin
				acc_q <= acc_q + 32'(prod_s2);
			end
		end
	end

	qlr_requant u_requant (
		.clk(clk), .arst_n(arst_n), .go(rq_go), .acc(acc_q), .mult(mult_q),
		.shift(shift_q), .ozp(ozp_q), .smode(smode_q), .done(rq_done), .byte_out(rq_byte));

	assign strobe = (state_q == ST_REQ) && rq_done;
	assign result.result_index = row_q;
	assign result.result_byte = rq_byte;
	assign result.result_last = ((ROW_W+1)'(row_q) + 1'b1 == nout_q);
endmodule

FILE: rtl/core/qlr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module qlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/qlr_requant.sv
// Multi-cycle exact requantization of one 32-bit accumulator to a byte.
// Depends on qlr_pkg.
`timescale 1ns / 1ps
module qlr_requant import qlr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [31:0]        acc,
	input  logic [30:0]        mult,
	input  logic [5:0]         shift,
	input  logic [8:0]         ozp,
	input  logic               smode,
	output logic               done,
	output logic [7:0]         byte_out
);
	logic [2:0] step_q;
	logic [31:0] mag_q;
	logic neg_q;
	logic [62:0] prod_q;
	logic [5:0] sh_q;
	logic [63:0] q_s;
	logic [63:0] r_s;
	logic [63:0] half_s;
	logic rnd_s;
	logic [63:0] qr_q;
	logic signed [66:0] v_s;
	logic signed [66:0] lo_s;
	logic signed [66:0] hi_s;
	logic signed [66:0] sat_s;

	// The product -acc*mult has the sign opposite to acc.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (go) begin
			step_q <= 3'd1;
		end else if (step_q != 3'd0) begin
			step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
		end
	end

	assign q_s = {1'b0, prod_q} >> sh_q;
	assign r_s = {1'b0, prod_q} & ((64'd1 << sh_q) - 64'd1);
	assign half_s = (sh_q == 6'd0) ? 64'd0 : (64'd1 << (sh_q - 6'd1));
	assign rnd_s = (sh_q != 6'd0) && ((r_s > half_s) || ((r_s == half_s) && q_s[0]));

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= !acc[31] && (acc != 32'd0);
			mag_q <= acc[31] ? (~acc + 32'd1) : acc;
			sh_q <= 6'd31 - shift;
		end
		if (step_q == 3'd1) begin
			prod_q <= 63'(mag_q) * 63'(mult);
		end
		if (step_q == 3'd2) begin
			qr_q <= q_s + {63'd0, rnd_s};
		end
	end

	assign lo_s = smode ? -67'sd128 : 67'sd0;
	assign hi_s = smode ? 67'sd127 : 67'sd255;
	assign v_s = (neg_q ? -$signed({3'b000, qr_q}) : $signed({3'b000, qr_q}))
		+ 67'(signed'(ozp));
	assign sat_s = (v_s < lo_s) ? lo_s : ((v_s > hi_s) ? hi_s : v_s);

	always_ff @(posedge clk) begin
		if (step_q == 3'd3) begin
			byte_out <= sat_s[7:0];
		end
	end
	assign done = (step_q == 3'd4);
endmodule

FILE: rtl/core/qlr_checker.sv
// Port-level checker for quantized_linear_requant, bound to the top level.
// Depends on qlr_pkg.
`timescale 1ns / 1ps
module qlr_checker import qlr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    strobe,
	input result_t result
);
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result transfer while idle");
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("results back to back");
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $rose(busy)) |-> 1'b0) else $error("result on first busy cycle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.result_last) |=> !busy) else $error("busy after last result");
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind_t'(item.kind) == KIND_ACT && item.row_end) |=> busy)
		else $error("no sweep after row end transfer");
endmodule

bind quantized_linear_requant qlr_checker u_qlr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
	.strobe(strobe), .result(result));
